// ===== rtl/i2bf_pkg.sv =====
package i2bf_pkg;

	localparam int VAL_W = 32;
	localparam int BF_W = 16;
	localparam logic [15:0] QNAN = 16'h7FC0;
	localparam logic [15:0] INF_MAG = 16'h7F80;
	localparam logic [15:0] QUIET_BIT = 16'h0040;

	// front-end decode: special case resolved, else operands for multiply
	typedef struct packed {
		logic        special;
		logic [15:0] special_bits;
		logic        sign;
		logic [23:0] m1;
		logic [7:0]  m2;
		logic signed [10:0] exp_sum;
	} i2bf_op_t;

	function automatic logic [5:0] lzc32(input logic [31:0] x);
		logic [5:0] n;
		n = 6'd32;
		for (int i = 0; i < 32; i++) begin
			if (x[i]) begin
				n = 6'(31 - i);
			end
		end
		return n;
	endfunction

	function automatic logic [3:0] lzc8(input logic [7:0] x);
		logic [3:0] n;
		n = 4'd8;
		for (int i = 0; i < 8; i++) begin
			if (x[i]) begin
				n = 4'(7 - i);
			end
		end
		return n;
	endfunction

endpackage

// ===== rtl/i2bf_decode.sv =====
// integer to fp32 with RNE, scale unpack, special cases
module i2bf_decode (
	input  logic [31:0] value,
	input  logic [15:0] scale_bits,
	output i2bf_pkg::i2bf_op_t op
);
	logic        sv, ss, sg;
	logic [7:0]  es;
	logic [6:0]  fs;
	logic [31:0] mag, norm;
	logic [5:0]  lz;
	logic [24:0] rnd;
	logic        g, st;
	logic [23:0] m1;
	logic [5:0]  e1;
	logic [3:0]  lz2;
	logic [7:0]  m2;
	logic signed [10:0] e2;

	always_comb begin
		sv = value[31];
		ss = scale_bits[15];
		sg = sv ^ ss;
		es = scale_bits[14:7];
		fs = scale_bits[6:0];
		mag = sv ? (~value + 32'd1) : value;
		lz = i2bf_pkg::lzc32(mag);
		norm = mag << lz[4:0];
		g = norm[7];
		st = |norm[6:0];
		rnd = {1'b0, norm[31:8]} + {24'd0, g & (st | norm[8])};
		// value = m1 * 2^e1, e1 = (31-lz) - 23
		if (rnd[24]) begin
			m1 = rnd[24:1];
			e1 = 6'd9 - lz;
		end else begin
			m1 = rnd[23:0];
			e1 = 6'd8 - lz;
		end
		// normalize scale mantissa to [128,256)
		if (es == 8'd0) begin
			lz2 = i2bf_pkg::lzc8({1'b0, fs});
			m2 = {1'b0, fs} << lz2[2:0];
			e2 = -11'sd133 - 11'(signed'({7'd0, lz2}));
		end else begin
			lz2 = 4'd0;
			m2 = {1'b1, fs};
			e2 = 11'(signed'({3'd0, es})) - 11'sd134;
		end
		op.sign = sg;
		op.m1 = m1;
		op.m2 = m2;
		op.exp_sum = e2 + 11'(signed'(e1));
		op.special = 1'b1;
		if (es == 8'hFF) begin
			if (fs != 7'd0) op.special_bits = scale_bits | i2bf_pkg::QUIET_BIT;
			else if (mag == 32'd0) op.special_bits = i2bf_pkg::QNAN;
			else op.special_bits = {sg, 15'd0} | i2bf_pkg::INF_MAG;
		end else if (mag == 32'd0 || scale_bits[14:0] == 15'd0) begin
			op.special_bits = {sg, 15'd0};
		end else begin
			op.special = 1'b0;
			op.special_bits = 16'd0;
		end
	end
endmodule

// ===== rtl/i2bf_round.sv =====
// product, round to fp32, then to bf16, with flush and overflow
module i2bf_round (
	input  i2bf_pkg::i2bf_op_t op,
	output logic [15:0] result
);
	logic [31:0] p;
	logic        top;
	logic [23:0] q;
	logic        g, st;
	logic [24:0] r;
	logic [23:0] mp;
	logic signed [11:0] ep, lead;
	logic [8:0]  rb;
	logic [7:0]  mb;
	logic signed [11:0] lb;

	always_comb begin
		p = op.m1 * {24'd0, op.m2};
		top = p[31];
		// m1,m2 normalized so p has 31 or 32 bits
		if (top) begin
			q = p[31:8]; g = p[7]; st = |p[6:0];
		end else begin
			q = p[30:7]; g = p[6]; st = |p[5:0];
		end
		r = {1'b0, q} + {24'd0, g & (st | q[0])};
		ep = 12'(op.exp_sum) + (top ? 12'sd8 : 12'sd7);
		if (r[24]) begin
			mp = r[24:1]; ep = ep + 12'sd1;
		end else begin
			mp = r[23:0];
		end
		lead = ep + 12'sd23;
		rb = {1'b0, mp[23:16]} + {8'd0, mp[15] & ((|mp[14:0]) | mp[16])};
		if (rb[8]) begin
			mb = rb[8:1]; lb = lead + 12'sd1;
		end else begin
			mb = rb[7:0]; lb = lead;
		end
		if (op.special) result = op.special_bits;
		else if (lead < -12'sd126) result = {op.sign, 15'd0};
		else if (lead > 12'sd127 || lb > 12'sd127)
			result = {op.sign, 15'd0} | i2bf_pkg::INF_MAG;
		else result = {op.sign, 8'(lb + 12'sd127), mb[6:0]};
	end
endmodule

// ===== rtl/int32_to_bf16_scaled_dequant.sv =====
// int32 x bf16 scale -> bf16 dequantization.
// Input channel: valid/ready with value (int32) and scale_bits (bf16).
// Output channel: result_valid/result_ready with result_bits (bf16).
// Decode (int->fp32 rounding, specials) runs before an operand register;
// multiply and both roundings run before the result register.
// The two register stages are the operand register and the result register;
// result_valid rises once an item has reached the result register.
// Throughput: one item per cycle while the receiver does not stall; each
// register advances whenever the stage after it is empty or being drained.
// When the receiver stalls, results hold in the output register and
// the pipeline fills; ready drops once both stages are occupied.
// Reset clears both stage valid bits; no item is held after reset.
// NaN/inf scales follow IEEE rules; denormal results flush to zero.
module int32_to_bf16_scaled_dequant (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        valid,
	output logic        ready,
	input  logic [31:0] value,
	input  logic [15:0] scale_bits,
	output logic        result_valid,
	input  logic        result_ready,
	output logic [15:0] result_bits
);
	i2bf_pkg::i2bf_op_t op_d, op_s1;
	logic        v_s1, v_s2, adv_s2;
	logic [15:0] res_d, res_s2;

	i2bf_decode u_dec (.value(value), .scale_bits(scale_bits), .op(op_d));
	i2bf_round  u_rnd (.op(op_s1), .result(res_d));

	assign adv_s2 = !v_s2 || result_ready;
	assign ready = !v_s1 || adv_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (ready) v_s1 <= valid;
			if (adv_s2) v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (ready && valid) op_s1 <= op_d;
		if (adv_s2 && v_s1) res_s2 <= res_d;
	end

	assign result_valid = v_s2;
	assign result_bits = res_s2;

`ifndef SYNTHESIS
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(result_bits))
		else $error("result dropped under stall");
	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		!ready |-> v_s1 && v_s2 && !result_ready)
		else $error("ready low without full pipe");
	a_flow: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && adv_s2 |=> result_valid)
		else $error("stage 1 item lost");
`endif
endmodule
